>>> rtl/bam_pkg.sv
`timescale 1ns / 1ps
package bam_pkg;
	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 13;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

	localparam logic [12:0] RESET_IMAGE_WIDTH  = 13'd640;
	localparam logic [12:0] RESET_IMAGE_HEIGHT = 13'd480;
	localparam logic [6:0]  RESET_BLOCK_SIZE   = 7'd8;

	// edge search window: requested edge*9/10 .. requested edge*11/10
	localparam int SEARCH_LO_NUM = 9;
	localparam int SEARCH_HI_NUM = 11;
	localparam int SEARCH_DEN    = 10;
	// reciprocal of the window denominator, exact for the products in range
	localparam int RECIP_SHIFT   = 16;
	localparam int RECIP_DEN     = (1 << RECIP_SHIFT) / SEARCH_DEN + 1;

	// payload widths
	localparam int PIX_W   = 8;
	localparam int SUM_W   = 21;
	localparam int COORD_W = 12;
	localparam int EDGE_W  = 7;

	typedef struct packed {
		logic first;
		logic last;
		logic last_cell;
	} bam_flags_t;
endpackage

>>> rtl/block_average_mosaic_unit.sv
`timescale 1ns / 1ps
// Box-average mosaic over a raster RGB pixel stream. The edge d is chosen
// at reset, at a pixel with frame_start set, and after the last pixel of a
// frame; during that search the input is stalled. The front takes one
// pixel a cycle, unless stalled by the search or a full queue, into a
// two-word queue; the back does one read-modify-write of the column-sum
// RAM for each pixel that lies in a whole cell, and on the last pixel of a
// cell also the 8-step average divide and the output load; it pops the
// next pixel only when it is through with the last one. Pixels outside
// every whole cell are never queued and give no result. Registers written
// mid-frame take effect only when the next frame begins.
module block_average_mosaic_unit #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_BLOCK  = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bam_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bam_pkg::PIX_W-1:0]         pixel_red,
	input  logic [bam_pkg::PIX_W-1:0]         pixel_green,
	input  logic [bam_pkg::PIX_W-1:0]         pixel_blue,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bam_pkg::PIX_W-1:0]         avg_red,
	output logic [bam_pkg::PIX_W-1:0]         avg_green,
	output logic [bam_pkg::PIX_W-1:0]         avg_blue,
	output logic [bam_pkg::COORD_W-1:0]       cell_column,
	output logic [bam_pkg::COORD_W-1:0]       cell_row,
	output logic [bam_pkg::EDGE_W-1:0]        cell_edge,
	output logic                              last_cell
);
	import bam_pkg::*;

	localparam int NWX = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1))
		? $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
	localparam int NW  = (NWX < 2) ? 2 : NWX;
	localparam int DW  = $clog2(MAX_BLOCK * SEARCH_HI_NUM / SEARCH_DEN + 1);
	localparam int FW  = $bits(bam_flags_t);
	localparam int QW  = FW + 2 * NW + DW + 3 * PIX_W;

	logic             q_push, q_full, q_pop, q_valid;
	bam_flags_t       f_flags, b_flags;
	logic [NW-1:0]    f_cx, f_cy, b_cx, b_cy;
	logic [DW-1:0]    f_d, b_d;
	logic [PIX_W-1:0] f_r, f_g, f_b, b_r, b_g, b_b;
	logic [QW-1:0]    q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	bam_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_BLOCK (MAX_BLOCK),
		.NW        (NW),
		.DW        (DW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_red  (pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue (pixel_blue),
		.frame_start(frame_start),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_flags    (f_flags),
		.q_cx       (f_cx),
		.q_cy       (f_cy),
		.q_d        (f_d),
		.q_red      (f_r),
		.q_green    (f_g),
		.q_blue     (f_b)
	);

	// pack and unpack the queue word
	assign q_wdata = {f_flags, f_cx, f_cy, f_d, f_r, f_g, f_b};
	assign {b_flags, b_cx, b_cy, b_d, b_r, b_g, b_b} = q_rdata;

	bam_fifo #(.WIDTH(QW)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_rdata)
	);

	bam_back #(
		.NW   (NW),
		.DW   (DW),
		.DEPTH(MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_flags    (b_flags),
		.q_cx       (b_cx),
		.q_cy       (b_cy),
		.q_d        (b_d),
		.q_red      (b_r),
		.q_green    (b_g),
		.q_blue     (b_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.avg_red    (avg_red),
		.avg_green  (avg_green),
		.avg_blue   (avg_blue),
		.cell_column(cell_column),
		.cell_row   (cell_row),
		.cell_edge  (cell_edge),
		.last_cell  (last_cell)
	);
endmodule

>>> rtl/bam_ram.sv
`timescale 1ns / 1ps
module bam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/bam_fifo.sv
`timescale 1ns / 1ps
module bam_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	// store word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> (!full || pop))
		else $error("queue push while full");
`endif
endmodule

>>> rtl/bam_front.sv
`timescale 1ns / 1ps
module bam_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int MAX_BLOCK  = 64,
	parameter int NW         = 13,
	parameter int DW         = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [bam_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bam_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bam_pkg::PIX_W-1:0]         pixel_red,
	input  logic [bam_pkg::PIX_W-1:0]         pixel_green,
	input  logic [bam_pkg::PIX_W-1:0]         pixel_blue,
	input  logic                              frame_start,
	input  logic                              q_full,
	output logic                              q_push,
	output bam_pkg::bam_flags_t               q_flags,
	output logic [NW-1:0]                     q_cx,
	output logic [NW-1:0]                     q_cy,
	output logic [DW-1:0]                     q_d,
	output logic [bam_pkg::PIX_W-1:0]         q_red,
	output logic [bam_pkg::PIX_W-1:0]         q_green,
	output logic [bam_pkg::PIX_W-1:0]         q_blue
);
	import bam_pkg::*;

	localparam int CW = $clog2(NW + 1);
	localparam logic [2:0] S_RUN  = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_FDIV = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [12:0]   width_q, height_q;
	logic [6:0]    block_q;
	logic [2:0]    state_q;
	logic          fresh_q, pend_q;
	logic [NW-1:0] w_q, h_q;
	logic [DW-1:0] hi_q, d_q, pick_q;
	logic [DW:0]   best_q;
	logic          have_q;
	logic [NW-1:0] nw_q, nh_q;
	logic [DW-1:0] rw_q, rh_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] frame_w_q, frame_h_q, across_q, down_q;
	logic [DW-1:0] edge_q;
	logic [NW-1:0] x_q, y_q, cx_q, cy_q;
	logic [DW-1:0] ox_q, oy_q;

	logic [31:0]   wv, hv, bv, w_c, h_c, bs_c, lo_p, hi_p, lo_c;
	logic [DW:0]   t_w, t_h, score;
	logic          ge_w, ge_h, better, div_end;
	logic [DW-1:0] rw_n, rh_n, pick_n;
	logic [NW-1:0] nw_n, nh_n;
	logic          in_cell, first, last, last_cell;
	logic          ox_end, oy_end, x_end, y_end;
	logic          need_latch, accept;

	// clamp registers and derive the search window
	always_comb begin
		wv   = 32'(width_q);
		hv   = 32'(height_q);
		bv   = 32'(block_q);
		w_c  = (wv == 32'd0) ? 32'd1 : ((wv > MAX_WIDTH) ? 32'(MAX_WIDTH) : wv);
		h_c  = (hv == 32'd0) ? 32'd1 : ((hv > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : hv);
		bs_c = (bv == 32'd0) ? 32'd1 : ((bv > MAX_BLOCK) ? 32'(MAX_BLOCK) : bv);
		lo_p = (bs_c * 32'(SEARCH_LO_NUM) * 32'(RECIP_DEN)) >> RECIP_SHIFT;
		hi_p = (bs_c * 32'(SEARCH_HI_NUM) * 32'(RECIP_DEN)) >> RECIP_SHIFT;
		lo_c = (lo_p == 32'd0) ? 32'd1 : lo_p;
	end

	// one restoring divide step on width and height
	always_comb begin
		t_w  = {rw_q, nw_q[NW-1]};
		t_h  = {rh_q, nh_q[NW-1]};
		ge_w = (t_w >= {1'b0, d_q});
		ge_h = (t_h >= {1'b0, d_q});
		rw_n = ge_w ? DW'(t_w - {1'b0, d_q}) : DW'(t_w);
		rh_n = ge_h ? DW'(t_h - {1'b0, d_q}) : DW'(t_h);
		nw_n = {nw_q[NW-2:0], ge_w};
		nh_n = {nh_q[NW-2:0], ge_h};
		score  = {1'b0, rw_q} + {1'b0, rh_q};
		better = !have_q || (score < best_q);
		pick_n = better ? d_q : pick_q;
		div_end = (cnt_q == CW'(NW - 1));
	end

	// classify the current raster position
	always_comb begin
		in_cell   = (cx_q < across_q) && (cy_q < down_q);
		ox_end    = (({1'b0, ox_q} + 1'b1) == {1'b0, edge_q});
		oy_end    = (({1'b0, oy_q} + 1'b1) == {1'b0, edge_q});
		x_end     = (({1'b0, x_q} + 1'b1) == {1'b0, frame_w_q});
		y_end     = (({1'b0, y_q} + 1'b1) == {1'b0, frame_h_q});
		first     = (ox_q == '0) && (oy_q == '0);
		last      = ox_end && oy_end;
		last_cell = (({1'b0, cx_q} + 1'b1) == {1'b0, across_q})
			&& (({1'b0, cy_q} + 1'b1) == {1'b0, down_q});
		need_latch = in_valid && frame_start && !fresh_q;
		in_stall   = (state_q != S_RUN) || need_latch || q_full;
		accept     = in_valid && !in_stall;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_IMAGE_WIDTH;
			height_q <= RESET_IMAGE_HEIGHT;
			block_q  <= RESET_BLOCK_SIZE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_BLOCK_SIZE:   block_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// edge search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_PREP: begin
				w_q    <= NW'(w_c);
				h_q    <= NW'(h_c);
				hi_q   <= DW'(hi_p);
				d_q    <= DW'(lo_c);
				pick_q <= DW'(bs_c);
				have_q <= 1'b0;
				nw_q   <= NW'(w_c);
				nh_q   <= NW'(h_c);
				rw_q   <= '0;
				rh_q   <= '0;
				cnt_q  <= '0;
			end
			S_DIV, S_FDIV: begin
				nw_q  <= nw_n;
				nh_q  <= nh_n;
				rw_q  <= rw_n;
				rh_q  <= rh_n;
				cnt_q <= cnt_q + 1'b1;
			end
			S_EVAL: begin
				if (better) begin
					best_q <= score;
				end
				pick_q <= pick_n;
				have_q <= 1'b1;
				d_q    <= (d_q == hi_q) ? pick_n : d_q + 1'b1;
				nw_q   <= w_q;
				nh_q   <= h_q;
				rw_q   <= '0;
				rh_q   <= '0;
				cnt_q  <= '0;
			end
			S_DONE: begin
				frame_w_q <= w_q;
				frame_h_q <= h_q;
				across_q  <= nw_q;
				down_q    <= nh_q;
				edge_q    <= d_q;
			end
			default: ;
		endcase
	end

	// sequencer and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_PREP;
			fresh_q <= 1'b0;
			pend_q  <= 1'b0;
			x_q     <= '0;
			y_q     <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
		end else begin
			case (state_q)
				S_RUN: begin
					if (accept) begin
						fresh_q <= 1'b0;
						if (x_end) begin
							x_q  <= '0;
							ox_q <= '0;
							cx_q <= '0;
							if (y_end) begin
								y_q     <= '0;
								oy_q    <= '0;
								cy_q    <= '0;
								pend_q  <= 1'b0;
								state_q <= S_PREP;
							end else begin
								y_q <= y_q + 1'b1;
								if (oy_end) begin
									oy_q <= '0;
									cy_q <= cy_q + 1'b1;
								end else begin
									oy_q <= oy_q + 1'b1;
								end
							end
						end else begin
							x_q <= x_q + 1'b1;
							if (ox_end) begin
								ox_q <= '0;
								cx_q <= cx_q + 1'b1;
							end else begin
								ox_q <= ox_q + 1'b1;
							end
						end
					end else if (need_latch) begin
						pend_q  <= 1'b1;
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_DIV;
				S_DIV: begin
					if (div_end) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: state_q <= (d_q == hi_q) ? S_FDIV : S_DIV;
				S_FDIV: begin
					if (div_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					x_q     <= '0;
					y_q     <= '0;
					cx_q    <= '0;
					cy_q    <= '0;
					ox_q    <= '0;
					oy_q    <= '0;
					fresh_q <= pend_q;
					state_q <= S_RUN;
				end
				default: state_q <= S_PREP;
			endcase
		end
	end

	// hand the classified word to the queue
	assign q_push  = accept && in_cell;
	assign q_flags = '{first: first, last: last, last_cell: last_cell};
	assign q_cx    = cx_q;
	assign q_cy    = cy_q;
	assign q_d     = edge_q;
	assign q_red   = pixel_red;
	assign q_green = pixel_green;
	assign q_blue  = pixel_blue;

`ifndef SYNTH
	a_stall_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_RUN) |-> in_stall)
		else $error("input taken during edge search");
	a_fresh_run: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> (state_q == S_RUN))
		else $error("fresh latch outside run state");
`endif
endmodule

>>> rtl/bam_back.sv
`timescale 1ns / 1ps
module bam_back #(
	parameter int NW    = 13,
	parameter int DW    = 7,
	parameter int DEPTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  bam_pkg::bam_flags_t               q_flags,
	input  logic [NW-1:0]                     q_cx,
	input  logic [NW-1:0]                     q_cy,
	input  logic [DW-1:0]                     q_d,
	input  logic [bam_pkg::PIX_W-1:0]         q_red,
	input  logic [bam_pkg::PIX_W-1:0]         q_green,
	input  logic [bam_pkg::PIX_W-1:0]         q_blue,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bam_pkg::PIX_W-1:0]         avg_red,
	output logic [bam_pkg::PIX_W-1:0]         avg_green,
	output logic [bam_pkg::PIX_W-1:0]         avg_blue,
	output logic [bam_pkg::COORD_W-1:0]       cell_column,
	output logic [bam_pkg::COORD_W-1:0]       cell_row,
	output logic [bam_pkg::EDGE_W-1:0]        cell_edge,
	output logic                              last_cell
);
	import bam_pkg::*;

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW  = 3 * SUM_W;
	localparam int DV  = (2 * DW + PIX_W > SUM_W + 1) ? 2 * DW + PIX_W : SUM_W + 1;
	localparam int KW  = $clog2(PIX_W);
	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_ADD  = 2'd1;
	localparam logic [1:0] B_DIV  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;

	logic [1:0]       state_q;
	bam_flags_t       e_flags_q;
	logic [NW-1:0]    e_cx_q, e_cy_q;
	logic [DW-1:0]    e_d_q;
	logic [PIX_W-1:0] e_r_q, e_g_q, e_b_q;
	logic [2*DW-1:0]  area_q;
	logic [DV-1:0]    rem_r_q, rem_g_q, rem_b_q, div_q;
	logic [PIX_W-1:0] quo_r_q, quo_g_q, quo_b_q;
	logic [KW-1:0]    k_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_r_q, out_g_q, out_b_q;
	logic [COORD_W-1:0] out_cx_q, out_cy_q;
	logic [EDGE_W-1:0]  out_d_q;
	logic             out_last_q;

	logic [RW-1:0]    rd_data, wr_data;
	logic [SUM_W-1:0] rd_r, rd_g, rd_b, sum_r, sum_g, sum_b;
	logic             ge_r, ge_g, ge_b, we, load_out;

	bam_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (e_cx_q[AW-1:0]),
		.wdata (wr_data),
		.re    (q_pop),
		.raddr (q_cx[AW-1:0]),
		.rdata (rd_data)
	);

	// accumulate the column sums
	always_comb begin
		rd_r  = rd_data[3*SUM_W-1 -: SUM_W];
		rd_g  = rd_data[2*SUM_W-1 -: SUM_W];
		rd_b  = rd_data[SUM_W-1 -: SUM_W];
		sum_r = e_flags_q.first ? SUM_W'(e_r_q) : rd_r + SUM_W'(e_r_q);
		sum_g = e_flags_q.first ? SUM_W'(e_g_q) : rd_g + SUM_W'(e_g_q);
		sum_b = e_flags_q.first ? SUM_W'(e_b_q) : rd_b + SUM_W'(e_b_q);
		wr_data = {sum_r, sum_g, sum_b};
		we      = (state_q == B_ADD);
		q_pop   = (state_q == B_IDLE) && q_valid;
		ge_r    = (rem_r_q >= div_q);
		ge_g    = (rem_g_q >= div_q);
		ge_b    = (rem_b_q >= div_q);
		load_out = (state_q == B_OUT) && (!out_valid_q || !out_stall);
	end

	// hold the popped word
	always_ff @(posedge clk) begin
		if (q_pop) begin
			e_flags_q <= q_flags;
			e_cx_q    <= q_cx;
			e_cy_q    <= q_cy;
			e_d_q     <= q_d;
			e_r_q     <= q_red;
			e_g_q     <= q_green;
			e_b_q     <= q_blue;
			area_q    <= q_d * q_d;
		end
	end

	// divide the three sums by the cell area, one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			B_ADD: begin
				rem_r_q <= DV'(sum_r);
				rem_g_q <= DV'(sum_g);
				rem_b_q <= DV'(sum_b);
				div_q   <= DV'(area_q) << (PIX_W - 1);
				k_q     <= '0;
			end
			B_DIV: begin
				rem_r_q <= ge_r ? rem_r_q - div_q : rem_r_q;
				rem_g_q <= ge_g ? rem_g_q - div_q : rem_g_q;
				rem_b_q <= ge_b ? rem_b_q - div_q : rem_b_q;
				quo_r_q <= {quo_r_q[PIX_W-2:0], ge_r};
				quo_g_q <= {quo_g_q[PIX_W-2:0], ge_g};
				quo_b_q <= {quo_b_q[PIX_W-2:0], ge_b};
				div_q   <= div_q >> 1;
				k_q     <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_r_q    <= quo_r_q;
			out_g_q    <= quo_g_q;
			out_b_q    <= quo_b_q;
			out_cx_q   <= COORD_W'(e_cx_q);
			out_cy_q   <= COORD_W'(e_cy_q);
			out_d_q    <= EDGE_W'(e_d_q);
			out_last_q <= e_flags_q.last_cell;
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: state_q <= e_flags_q.last ? B_DIV : B_IDLE;
				B_DIV: begin
					if (k_q == KW'(PIX_W - 1)) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign avg_red     = out_r_q;
	assign avg_green   = out_g_q;
	assign avg_blue    = out_b_q;
	assign cell_column = out_cx_q;
	assign cell_row    = out_cy_q;
	assign cell_edge   = out_d_q;
	assign last_cell   = out_last_q;

`ifndef SYNTH
	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == B_OUT))
		else $error("result shown without a finished divide");
`endif
endmodule
